FILE: design/cpa_pkg.sv
// ----------------------------------------------------------------------------
// cpa_pkg
// Shared widths, constants, register indexes and helper types for the
// AC current peak ammeter.
// ----------------------------------------------------------------------------
package cpa_pkg;

	// Fixed-point format of the smoothed value: ADC_BITS integer, FRAC_BITS fraction
	localparam int ADC_BITS   = 10;
	localparam int FRAC_BITS  = 16;
	localparam int VAL_W      = ADC_BITS + FRAC_BITS;

	// Smoothing factor, Q0.16; one extra bit holds (1.0 - alpha)
	localparam int ALPHA_W    = 16;
	localparam int ALPHA_OPW  = ALPHA_W + 1;
	localparam int TERM_W     = ALPHA_W + ADC_BITS;
	localparam int PROD_W     = ALPHA_OPW + VAL_W;
	localparam int SUM_W      = PROD_W + 1;

	// Register widths
	localparam int CAL_W      = 10;
	localparam int SPW_W      = 16;
	localparam int WPS_W      = 8;
	localparam int LIMIT_W    = 10;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Amperes in Q10.8
	localparam int AMPS_W     = 18;
	localparam int AMPS_FRAC  = 8;
	localparam int AMPS_SHIFT = FRAC_BITS - AMPS_FRAC;
	localparam int NOISE_W    = FRAC_BITS + 2;

	// Shared divider
	localparam int DIV_W      = VAL_W;
	localparam int DIVR_W     = CAL_W;
	localparam int DIV_CNT_W  = $clog2(DIV_W + 1);

	localparam logic [VAL_W-1:0]     MID_RESET = VAL_W'(64'd512 << FRAC_BITS);
	localparam logic [VAL_W-1:0]     NOISE_LIM = VAL_W'(64'd4 << FRAC_BITS);
	localparam logic [ALPHA_OPW-1:0] ALPHA_ONE = ALPHA_OPW'(64'd1 << ALPHA_W);
	localparam logic [AMPS_W-1:0]    AMPS_MAX  = '1;

	localparam logic [ALPHA_W-1:0] ALPHA_RST = ALPHA_W'(6554);
	localparam logic [CAL_W-1:0]   CAL_RST   = CAL_W'(100);
	localparam logic [SPW_W-1:0]   SPW_RST   = SPW_W'(1000);
	localparam logic [WPS_W-1:0]   WPS_RST   = WPS_W'(10);
	localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(30);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ALPHA     = 3'd0,
		REG_CALIB     = 3'd1,
		REG_SPW       = 3'd2,
		REG_WPS       = 3'd3,
		REG_AMP_LIMIT = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  dividend;
		logic [DIVR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

	function automatic logic [AMPS_W-1:0] sat_amps(input logic [DIV_W-1:0] v);
		logic [AMPS_W-1:0] r;
		if (v > DIV_W'(AMPS_MAX)) begin
			r = AMPS_MAX;
		end else begin
			r = v[AMPS_W-1:0];
		end
		return r;
	endfunction

endpackage

FILE: design/cpa_if.sv
// ----------------------------------------------------------------------------
// cpa_if
// Valid/ready channels of the AC current peak ammeter: sample in, result out.
// ----------------------------------------------------------------------------
interface cpa_in_if;
	logic                         valid;
	logic                         ready;
	logic [cpa_pkg::ADC_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface cpa_out_if;
	logic                       valid;
	logic                       ready;
	logic [cpa_pkg::VAL_W-1:0]  peak;
	logic [cpa_pkg::VAL_W-1:0]  midpoint;
	logic [cpa_pkg::AMPS_W-1:0] amps;
	logic                       ready_res;
	logic [cpa_pkg::AMPS_W-1:0] slow_amps;
	logic                       slow_valid;

	modport source (output valid, output peak, output midpoint, output amps,
		output ready_res, output slow_amps, output slow_valid, input ready);
	modport sink   (input valid, input peak, input midpoint, input amps,
		input ready_res, input slow_amps, input slow_valid, output ready);
endinterface

FILE: design/cpa_mul.sv
// ----------------------------------------------------------------------------
// cpa_mul
// Shared 17x26 multiplier with registered product.
// ----------------------------------------------------------------------------
module cpa_mul (
	input  logic                            clk,
	input  logic [cpa_pkg::ALPHA_OPW-1:0]   a,
	input  logic [cpa_pkg::VAL_W-1:0]       b,
	output logic [cpa_pkg::PROD_W-1:0]      p_q
);

	always_ff @(posedge clk) begin
		p_q <= cpa_pkg::PROD_W'(a) * cpa_pkg::PROD_W'(b);
	end

endmodule

FILE: design/cpa_div.sv
// ----------------------------------------------------------------------------
// cpa_div
// Restoring divider, one quotient bit per cycle; done pulses when finished.
// ----------------------------------------------------------------------------
module cpa_div (
	input  logic              clk,
	input  logic              arst_n,
	input  cpa_pkg::div_req_t req,
	output cpa_pkg::div_rsp_t rsp
);

	logic                             busy_q;
	logic                             done_q;
	logic [cpa_pkg::DIV_CNT_W-1:0]    cnt_q;
	logic [cpa_pkg::DIVR_W-1:0]       rem_q;
	logic [cpa_pkg::DIV_W-1:0]        quo_q;
	logic [cpa_pkg::DIVR_W-1:0]       dvs_q;
	logic [cpa_pkg::DIVR_W:0]         shl;
	logic [cpa_pkg::DIVR_W:0]         sub;
	logic                             ge;

	assign shl = {rem_q, quo_q[cpa_pkg::DIV_W-1]};
	assign sub = shl - {1'b0, dvs_q};
	assign ge  = (shl >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= cpa_pkg::DIV_CNT_W'(cpa_pkg::DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == cpa_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? sub[cpa_pkg::DIVR_W-1:0] : shl[cpa_pkg::DIVR_W-1:0];
			quo_q <= {quo_q[cpa_pkg::DIV_W-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

FILE: design/ac_current_peak_ammeter_core.sv
// ----------------------------------------------------------------------------
// ac_current_peak_ammeter_core
// Moving-average peak tracker that turns raw current-sensor samples into
// per-window amperes, a midpoint estimate and a slow average.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one 10-bit ADC sample per item. out_ch carries one result
//   item per window of samples_per_window samples (none for other samples):
//   window peak, new midpoint, amps (Q10.8), ready flag and slow average.
//   cfg_we/cfg_index/cfg_data write the five registers; write only while idle.
// Operation:
//   A sample that closes no window passes through the multiply, update and
//   compare steps; the next sample is accepted once it is done. The
//   moving-average step is two passes through the one shared 17x26
//   multiplier plus an add and a max/min compare. A window-closing sample
//   adds the midpoint and noise-cleaning steps and one pass through the
//   shared restoring divider for amps before the result register loads;
//   the next sample is taken after the result is emitted. When the slow
//   interval closes a second divider pass follows before the result.
// Reset:
//   arst_n clears the registers to their defaults, smoothed value to zero and
//   midpoint/peak/valley seeds to 512.0; the block is ready at once.
// Stall:
//   A held result sits in the output register while the next samples are
//   taken; a new result waits in the last step until the old one is taken.
// ----------------------------------------------------------------------------
module ac_current_peak_ammeter_core (
	input  logic                             clk,
	input  logic                             arst_n,
	cpa_in_if.sink                           in_ch,
	cpa_out_if.source                        out_ch,
	input  logic                             cfg_we,
	input  logic [cpa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [cpa_pkg::CFG_DATA_W-1:0]   cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL_A,     // alpha * sample
		S_MUL_B,     // (1 - alpha) * smoothed
		S_UPD,       // new smoothed value
		S_CMP,       // max/min tracking, window count
		S_MID,       // new midpoint
		S_CLEAN,     // noise cleaning, start amps division
		S_DIV_AMPS,
		S_SLOW,      // slow average bookkeeping
		S_DIV_SLOW,
		S_EMIT
	} state_t;

	state_t state_q;

	// Configuration
	logic [cpa_pkg::ALPHA_W-1:0]  alpha_q;
	logic [cpa_pkg::CAL_W-1:0]    calib_q;
	logic [cpa_pkg::SPW_W-1:0]    spw_q;
	logic [cpa_pkg::WPS_W-1:0]    wps_q;
	logic [cpa_pkg::LIMIT_W-1:0]  limit_q;

	// Measurement state
	logic [cpa_pkg::ADC_BITS-1:0] sample_q;
	logic [cpa_pkg::TERM_W-1:0]   term_q;
	logic [cpa_pkg::VAL_W-1:0]    smoothed_q;
	logic [cpa_pkg::VAL_W-1:0]    run_max_q;
	logic [cpa_pkg::VAL_W-1:0]    run_min_q;
	logic [cpa_pkg::VAL_W-1:0]    mid_q;
	logic [cpa_pkg::NOISE_W-1:0]  noise_q;
	logic [cpa_pkg::SPW_W-1:0]    cnt_q;
	logic                         slow_active_q;
	logic [cpa_pkg::VAL_W-1:0]    slow_sum_q;
	logic [cpa_pkg::WPS_W-1:0]    wcnt_q;
	logic [cpa_pkg::AMPS_W-1:0]   slow_value_q;
	logic [cpa_pkg::AMPS_W-1:0]   amps_q;
	logic                         slow_flag_q;

	// Output register
	logic                         out_valid_q;
	logic [cpa_pkg::VAL_W-1:0]    out_peak_q;
	logic [cpa_pkg::VAL_W-1:0]    out_mid_q;
	logic [cpa_pkg::AMPS_W-1:0]   out_amps_q;
	logic                         out_rdy_q;
	logic [cpa_pkg::AMPS_W-1:0]   out_slow_q;
	logic                         out_sflag_q;

	// Shared units
	logic [cpa_pkg::ALPHA_OPW-1:0] mul_a;
	logic [cpa_pkg::VAL_W-1:0]     mul_b;
	logic [cpa_pkg::PROD_W-1:0]    mul_p;
	cpa_pkg::div_req_t             div_req;
	cpa_pkg::div_rsp_t             div_rsp;

	// Datapath
	logic [cpa_pkg::SUM_W-1:0]     sum_full;
	logic [cpa_pkg::VAL_W-1:0]     new_smoothed;
	logic [cpa_pkg::VAL_W-1:0]     max_seed;
	logic [cpa_pkg::VAL_W-1:0]     min_seed;
	logic [cpa_pkg::SPW_W-1:0]     cnt_next;
	logic [cpa_pkg::SPW_W-1:0]     spw_eff;
	logic                          window_end;
	logic [cpa_pkg::VAL_W-1:0]     diff;
	logic [cpa_pkg::NOISE_W-1:0]   noise_new;
	logic [cpa_pkg::VAL_W-1:0]     height;
	logic [cpa_pkg::CAL_W-1:0]     cal_eff;
	logic [cpa_pkg::WPS_W-1:0]     wps_eff;
	logic [cpa_pkg::WPS_W-1:0]     wc_cur;
	logic [cpa_pkg::VAL_W-1:0]     ss_cur;
	logic                          slow_add;
	logic                          emit_go;
	logic                          out_take;

	cpa_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_p)
	);

	cpa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Multiplier operands: alpha * sample first, then (1 - alpha) * smoothed
	always_comb begin
		if (state_q == S_MUL_A) begin
			mul_a = {1'b0, alpha_q};
			mul_b = cpa_pkg::VAL_W'(sample_q);
		end else begin
			mul_a = cpa_pkg::ALPHA_ONE - {1'b0, alpha_q};
			mul_b = smoothed_q;
		end
	end

	// (alpha * (sample << FRAC) + (1 - alpha) * smoothed) >> 16
	assign sum_full     = cpa_pkg::SUM_W'({term_q, {cpa_pkg::FRAC_BITS{1'b0}}})
	                      + cpa_pkg::SUM_W'(mul_p);
	assign new_smoothed = sum_full[cpa_pkg::ALPHA_W +: cpa_pkg::VAL_W];

	// A window starts from the previous midpoint
	assign max_seed   = (cnt_q == '0) ? mid_q : run_max_q;
	assign min_seed   = (cnt_q == '0) ? mid_q : run_min_q;
	assign cnt_next   = cnt_q + 1'b1;
	assign spw_eff    = (spw_q == '0) ? cpa_pkg::SPW_W'(1) : spw_q;
	assign window_end = (cnt_next == '0) || (cnt_next >= spw_eff);

	// Noise cleaning: a peak height under 4 counts becomes the offset
	assign diff      = run_max_q - mid_q;
	assign noise_new = (diff < cpa_pkg::NOISE_LIM) ? diff[cpa_pkg::NOISE_W-1:0] : noise_q;
	assign height    = (diff >= cpa_pkg::VAL_W'(noise_new))
	                   ? diff - cpa_pkg::VAL_W'(noise_new) : '0;
	assign cal_eff   = (calib_q == '0) ? cpa_pkg::CAL_W'(1) : calib_q;

	// Slow average: an inactive interval restarts from zero
	assign wps_eff  = (wps_q == '0) ? cpa_pkg::WPS_W'(1) : wps_q;
	assign wc_cur   = slow_active_q ? wcnt_q : '0;
	assign ss_cur   = slow_active_q ? slow_sum_q : '0;
	assign slow_add = (wc_cur < wps_eff);

	// Divider request: amps = (height >> (FRAC-8)) / calib, slow = sum / count
	always_comb begin
		div_req = '0;
		if (state_q == S_CLEAN) begin
			div_req.start    = 1'b1;
			div_req.dividend = height >> cpa_pkg::AMPS_SHIFT;
			div_req.divisor  = cal_eff;
		end else if (state_q == S_SLOW) begin
			div_req.start    = !slow_add;
			div_req.dividend = slow_sum_q;
			div_req.divisor  = cpa_pkg::DIVR_W'(wcnt_q);
		end
	end

	assign out_take = out_valid_q && out_ch.ready;
	assign emit_go  = (state_q == S_EMIT) && (!out_valid_q || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			alpha_q       <= cpa_pkg::ALPHA_RST;
			calib_q       <= cpa_pkg::CAL_RST;
			spw_q         <= cpa_pkg::SPW_RST;
			wps_q         <= cpa_pkg::WPS_RST;
			limit_q       <= cpa_pkg::LIMIT_RST;
			smoothed_q    <= '0;
			run_max_q     <= cpa_pkg::MID_RESET;
			run_min_q     <= cpa_pkg::MID_RESET;
			mid_q         <= cpa_pkg::MID_RESET;
			noise_q       <= '0;
			cnt_q         <= '0;
			slow_active_q <= 1'b0;
			slow_sum_q    <= '0;
			wcnt_q        <= '0;
			slow_value_q  <= '0;
			slow_flag_q   <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					cpa_pkg::REG_ALPHA:     alpha_q <= cfg_data[cpa_pkg::ALPHA_W-1:0];
					cpa_pkg::REG_CALIB:     calib_q <= cfg_data[cpa_pkg::CAL_W-1:0];
					cpa_pkg::REG_SPW:       spw_q   <= cfg_data[cpa_pkg::SPW_W-1:0];
					cpa_pkg::REG_WPS:       wps_q   <= cfg_data[cpa_pkg::WPS_W-1:0];
					cpa_pkg::REG_AMP_LIMIT: limit_q <= cfg_data[cpa_pkg::LIMIT_W-1:0];
					default: ;
				endcase
			end

			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						state_q <= S_MUL_A;
					end
				end
				S_MUL_A: begin
					state_q <= S_MUL_B;
				end
				S_MUL_B: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					smoothed_q <= new_smoothed;
					state_q    <= S_CMP;
				end
				S_CMP: begin
					run_max_q <= (smoothed_q > max_seed) ? smoothed_q : max_seed;
					run_min_q <= (smoothed_q < min_seed) ? smoothed_q : min_seed;
					if (window_end) begin
						cnt_q   <= '0;
						state_q <= S_MID;
					end else begin
						cnt_q   <= cnt_next;
						state_q <= S_IDLE;
					end
				end
				S_MID: begin
					mid_q   <= run_min_q + ((run_max_q - run_min_q) >> 1);
					state_q <= S_CLEAN;
				end
				S_CLEAN: begin
					noise_q <= noise_new;
					state_q <= S_DIV_AMPS;
				end
				S_DIV_AMPS: begin
					if (div_rsp.done) begin
						state_q <= S_SLOW;
					end
				end
				S_SLOW: begin
					if (slow_add) begin
						slow_sum_q    <= ss_cur + cpa_pkg::VAL_W'(amps_q);
						wcnt_q        <= wc_cur + 1'b1;
						slow_active_q <= 1'b1;
						slow_flag_q   <= 1'b0;
						state_q       <= S_EMIT;
					end else begin
						slow_active_q <= 1'b0;
						slow_flag_q   <= 1'b1;
						state_q       <= S_DIV_SLOW;
					end
				end
				S_DIV_SLOW: begin
					if (div_rsp.done) begin
						slow_value_q <= cpa_pkg::sat_amps(div_rsp.quotient);
						state_q      <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit_go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_ch.valid) begin
			sample_q <= in_ch.sample;
		end
		if (state_q == S_MUL_B) begin
			term_q <= mul_p[cpa_pkg::TERM_W-1:0];
		end
		if (state_q == S_DIV_AMPS && div_rsp.done) begin
			amps_q <= cpa_pkg::sat_amps(div_rsp.quotient);
		end
		if (emit_go) begin
			out_peak_q  <= run_max_q;
			out_mid_q   <= mid_q;
			out_amps_q  <= amps_q;
			out_rdy_q   <= (amps_q <= cpa_pkg::AMPS_W'({limit_q,
			               {cpa_pkg::AMPS_FRAC{1'b0}}}));
			out_slow_q  <= slow_value_q;
			out_sflag_q <= slow_flag_q;
		end
	end

	assign in_ch.ready       = (state_q == S_IDLE);
	assign out_ch.valid      = out_valid_q;
	assign out_ch.peak       = out_peak_q;
	assign out_ch.midpoint   = out_mid_q;
	assign out_ch.amps       = out_amps_q;
	assign out_ch.ready_res  = out_rdy_q;
	assign out_ch.slow_amps  = out_slow_q;
	assign out_ch.slow_valid = out_sflag_q;

endmodule

FILE: design/cpa_checker.sv
// ----------------------------------------------------------------------------
// cpa_checker
// Port-level checks of the AC current peak ammeter, bound to the top level.
// ----------------------------------------------------------------------------
module cpa_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic [cpa_pkg::VAL_W-1:0]  out_peak,
	input  logic [cpa_pkg::VAL_W-1:0]  out_midpoint
);

	// One item at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input still ready after accept");

	// A result only comes out of work on an item
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared while idle");

	// Midpoint lies at or below the peak
	a_mid_below_peak: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_midpoint <= out_peak))
		else $error("midpoint above peak");

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_peak)
		&& $stable(out_midpoint)))
		else $error("stalled result changed");

endmodule

bind ac_current_peak_ammeter_core cpa_checker u_cpa_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_ch.valid),
	.in_ready     (in_ch.ready),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.out_peak     (out_ch.peak),
	.out_midpoint (out_ch.midpoint)
);

FILE: tb/ac_current_peak_ammeter_core_tb.sv
// ----------------------------------------------------------------------------
// ac_current_peak_ammeter_core_tb
// Self-checking bench for the peak ammeter core. A queue-fed driver sends ADC
// samples, a per-sample predictor of the moving average, window peak and
// slow average builds the expected window results, and a monitor compares
// every result item field by field. Both channels stall at random.
// ----------------------------------------------------------------------------
module ac_current_peak_ammeter_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int GAP_PCT       = 32;    // idle chance per cycle on each side
	localparam int SETTLE_CYCLES = 100;   // covers a non-closing sample and margin
	localparam int STALL_LIMIT   = 4000;  // cycles with no item moving on either side
	localparam int RAND_PHASES   = 10;

	// indexes with no register behind them; writes there must not land anywhere
	localparam logic [cpa_pkg::CFG_IDX_W-1:0] REG_SPARE  = 3'd5;
	localparam logic [cpa_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	localparam logic [63:0] AMPS_TOP = (64'd1 << cpa_pkg::AMPS_W) - 64'd1;

	typedef struct packed {
		logic [cpa_pkg::VAL_W-1:0]  peak;
		logic [cpa_pkg::VAL_W-1:0]  midpoint;
		logic [cpa_pkg::AMPS_W-1:0] amps;
		logic                       ready_res;
		logic [cpa_pkg::AMPS_W-1:0] slow_amps;
		logic                       slow_valid;
	} window_result_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [cpa_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [cpa_pkg::CFG_DATA_W-1:0] cfg_data;

	cpa_in_if  in_ch ();
	cpa_out_if out_ch ();

	ac_current_peak_ammeter_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Register shadow, kept in step with every write to the block
	logic [cpa_pkg::ALPHA_W-1:0] cfg_alpha;
	logic [cpa_pkg::CAL_W-1:0]   cfg_calib;
	logic [cpa_pkg::SPW_W-1:0]   cfg_spw;
	logic [cpa_pkg::WPS_W-1:0]   cfg_wps;
	logic [cpa_pkg::LIMIT_W-1:0] cfg_limit;

	// Meter state as the block should hold it
	logic [cpa_pkg::VAL_W-1:0]   ema_val;
	logic [cpa_pkg::VAL_W-1:0]   win_hi;
	logic [cpa_pkg::VAL_W-1:0]   win_lo;
	logic [cpa_pkg::VAL_W-1:0]   mid_lvl;
	logic [cpa_pkg::NOISE_W-1:0] noise_off;
	logic [cpa_pkg::SPW_W-1:0]   smp_cnt;
	logic                        slow_run;
	logic [cpa_pkg::VAL_W-1:0]   slow_acc;
	logic [cpa_pkg::WPS_W-1:0]   win_cnt;
	logic [cpa_pkg::AMPS_W-1:0]  slow_avg;

	logic [cpa_pkg::ADC_BITS-1:0] sample_q [$];   // samples waiting for the driver
	window_result_t               window_q [$];   // window results still owed by the block

	int errors          = 0;
	int samples_taken   = 0;
	int windows_checked = 0;
	int slow_updates    = 0;
	int settings        = 0;
	int idle_cycles     = 0;
	bit sample_taken    = 1'b0;
	bit no_gaps         = 1'b0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic flag_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		errors++;
		$display("mismatch at window %0d: %s got 0x%0h, want 0x%0h",
			windows_checked, what, got, want);
	endtask

	// One sample through the meter. Arithmetic runs in 64 bits, wide enough
	// for every intermediate of the step.
	task automatic meter_step(input logic [cpa_pkg::ADC_BITS-1:0] smp);
		logic [63:0]    spw, cal, wps, acc, diff, cleaned, amps_v, avg;
		window_result_t r;
		spw = (cfg_spw == '0) ? 64'd1 : 64'(cfg_spw);
		cal = (cfg_calib == '0) ? 64'd1 : 64'(cfg_calib);
		wps = (cfg_wps == '0) ? 64'd1 : 64'(cfg_wps);

		// window opens: seed peak and valley with the last midpoint
		if (smp_cnt == '0) begin
			win_hi = mid_lvl;
			win_lo = mid_lvl;
		end

		acc = (64'(cfg_alpha) * (64'(smp) << cpa_pkg::FRAC_BITS))
			+ ((64'd65536 - 64'(cfg_alpha)) * 64'(ema_val));
		ema_val = cpa_pkg::VAL_W'(acc >> 16);
		if (ema_val > win_hi) win_hi = ema_val;
		if (ema_val < win_lo) win_lo = ema_val;

		smp_cnt = smp_cnt + 1'b1;
		if (smp_cnt != '0 && 64'(smp_cnt) < spw) return;
		smp_cnt = '0;

		mid_lvl = win_lo + ((win_hi - win_lo) >> 1);

		// small swing around the midpoint is taken as noise and remembered
		diff = 64'(win_hi - mid_lvl);
		if (diff < (64'd4 << cpa_pkg::FRAC_BITS)) noise_off = cpa_pkg::NOISE_W'(diff);
		cleaned = 64'(win_hi) - 64'(noise_off);
		if (cleaned < 64'(mid_lvl)) cleaned = 64'(mid_lvl);

		amps_v = ((cleaned - 64'(mid_lvl)) << 8) / (cal << cpa_pkg::FRAC_BITS);
		if (amps_v > AMPS_TOP) amps_v = AMPS_TOP;

		// slow average: the window after the last counted one closes it
		r.slow_valid = 1'b0;
		if (!slow_run) begin
			win_cnt  = '0;
			slow_acc = '0;
			slow_run = 1'b1;
		end
		if (64'(win_cnt) < wps) begin
			slow_acc = slow_acc + cpa_pkg::VAL_W'(amps_v);
			win_cnt  = win_cnt + 1'b1;
		end else begin
			avg = (win_cnt != '0) ? 64'(slow_acc) / 64'(win_cnt) : 64'd0;
			if (avg > AMPS_TOP) avg = AMPS_TOP;
			slow_avg     = cpa_pkg::AMPS_W'(avg);
			slow_run     = 1'b0;
			r.slow_valid = 1'b1;
		end

		r.peak      = win_hi;
		r.midpoint  = mid_lvl;
		r.amps      = cpa_pkg::AMPS_W'(amps_v);
		r.ready_res = (amps_v <= (64'(cfg_limit) << 8));
		r.slow_amps = slow_avg;
		window_q.push_back(r);
	endtask

	// Register write on the plain port; the shadow follows once it has landed
	task automatic write_reg(input logic [cpa_pkg::CFG_IDX_W-1:0] idx,
			input logic [cpa_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			cpa_pkg::REG_ALPHA:     cfg_alpha = data[cpa_pkg::ALPHA_W-1:0];
			cpa_pkg::REG_CALIB:     cfg_calib = data[cpa_pkg::CAL_W-1:0];
			cpa_pkg::REG_SPW:       cfg_spw   = data[cpa_pkg::SPW_W-1:0];
			cpa_pkg::REG_WPS:       cfg_wps   = data[cpa_pkg::WPS_W-1:0];
			cpa_pkg::REG_AMP_LIMIT: cfg_limit = data[cpa_pkg::LIMIT_W-1:0];
			default: ;
		endcase
	endtask

	// One shaped stretch of samples: mostly an AC waveform (triangle around
	// mid-scale with jitter), else full-range noise, rails, or a flat line
	// whose tiny swing drives the noise-offset path.
	task automatic queue_burst(input int n);
		int i, kind, amp, per, half, base, jit, p, v;
		kind = $urandom_range(0, 99);
		amp  = $urandom_range(0, 511);
		per  = $urandom_range(4, 64);
		half = per / 2;
		base = 504 + $urandom_range(0, 16);
		jit  = $urandom_range(0, 3);
		for (i = 0; i < n; i++) begin
			if (kind < 60) begin
				p = i % per;
				v = (p < half) ? -amp + (2 * amp * p) / half
					: amp - (2 * amp * (p - half)) / (per - half);
				v = v + base + $urandom_range(0, 2 * jit) - jit;
			end else if (kind < 72) begin
				v = $urandom_range(0, 1023);
			end else if (kind < 82) begin
				v = $urandom_range(0, 7);
			end else if (kind < 90) begin
				v = 1023 - $urandom_range(0, 7);
			end else begin
				v = base + $urandom_range(0, 6) - 3;
			end
			if (v < 0) v = 0;
			if (v > 1023) v = 1023;
			sample_q.push_back(cpa_pkg::ADC_BITS'(v));
		end
	endtask

	task automatic queue_samples(input int total);
		int n;
		while (total > 0) begin
			n = $urandom_range(8, 64);
			if (n > total) n = total;
			queue_burst(n);
			total -= n;
		end
	endtask

	// Wait for every sample to be taken and every owed result to arrive, then
	// give the block time to finish a sample that closes no window.
	task automatic settle();
		while (sample_q.size() != 0 || in_ch.valid || window_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Sample driver: offers the next queued sample once the current one is
	// taken, or idles at random.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else if (!in_ch.valid || sample_taken) begin
			if (sample_q.size() != 0 && (no_gaps || $urandom_range(0, 99) >= GAP_PCT)) begin
				in_ch.valid  <= 1'b1;
				in_ch.sample <= sample_q.pop_front();
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// Result side back-pressure
	always @(negedge clk) begin
		out_ch.ready <= arst_n && (no_gaps || $urandom_range(0, 99) >= GAP_PCT);
	end

	// Accepted samples feed the predictor
	always @(posedge clk) begin
		sample_taken = arst_n && in_ch.valid && (in_ch.ready === 1'b1);
		if (sample_taken) begin
			samples_taken++;
			meter_step(in_ch.sample);
		end
	end

	// Result monitor: each accepted result against the oldest expectation
	always @(posedge clk) begin
		window_result_t got, want;
		if (arst_n && out_ch.valid === 1'b1 && out_ch.ready) begin
			got.peak       = out_ch.peak;
			got.midpoint   = out_ch.midpoint;
			got.amps       = out_ch.amps;
			got.ready_res  = out_ch.ready_res;
			got.slow_amps  = out_ch.slow_amps;
			got.slow_valid = out_ch.slow_valid;
			if (window_q.size() == 0) begin
				flag_mismatch("result item with none owed", 64'd1, 64'd0);
			end else begin
				want = window_q.pop_front();
				if (got.peak !== want.peak)
					flag_mismatch("peak", 64'(got.peak), 64'(want.peak));
				if (got.midpoint !== want.midpoint)
					flag_mismatch("midpoint", 64'(got.midpoint), 64'(want.midpoint));
				if (got.amps !== want.amps)
					flag_mismatch("amps", 64'(got.amps), 64'(want.amps));
				if (got.ready_res !== want.ready_res)
					flag_mismatch("ready_res", 64'(got.ready_res), 64'(want.ready_res));
				if (got.slow_amps !== want.slow_amps)
					flag_mismatch("slow_amps", 64'(got.slow_amps), 64'(want.slow_amps));
				if (got.slow_valid !== want.slow_valid)
					flag_mismatch("slow_valid", 64'(got.slow_valid),
						64'(want.slow_valid));
				if (want.slow_valid) slow_updates++;
			end
			windows_checked++;
		end
	end

	// Watchdog: too long with no item moving on either channel
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready === 1'b1) || (out_ch.valid === 1'b1 && out_ch.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("stalled for %0d cycles with %0d results owed", idle_cycles,
				window_q.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		int                          ph, n;
		logic [cpa_pkg::ALPHA_W-1:0] alpha_v;
		logic [cpa_pkg::CAL_W-1:0]   cal_v;
		logic [cpa_pkg::SPW_W-1:0]   spw_v;
		logic [cpa_pkg::WPS_W-1:0]   wps_v;
		logic [cpa_pkg::LIMIT_W-1:0] lim_v;

		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = cpa_pkg::REG_ALPHA;
		cfg_data     = '0;
		in_ch.valid  = 1'b0;
		in_ch.sample = '0;
		out_ch.ready = 1'b0;

		// power-up values of registers and meter state
		cfg_alpha = 16'd6554;
		cfg_calib = 10'd100;
		cfg_spw   = 16'd1000;
		cfg_wps   = 8'd10;
		cfg_limit = 10'd30;
		ema_val   = '0;
		win_hi    = cpa_pkg::VAL_W'(64'd512 << cpa_pkg::FRAC_BITS);
		win_lo    = cpa_pkg::VAL_W'(64'd512 << cpa_pkg::FRAC_BITS);
		mid_lvl   = cpa_pkg::VAL_W'(64'd512 << cpa_pkg::FRAC_BITS);
		noise_off = '0;
		smp_cnt   = '0;
		slow_run  = 1'b0;
		slow_acc  = '0;
		win_cnt   = '0;
		slow_avg  = '0;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: rail and mid-scale samples under power-up settings; the
		// default window is long, so none of these may produce a result.
		sample_q = '{10'd0, 10'd1023, 10'd1023, 10'd512, 10'd0, 10'd1, 10'd1022, 10'd511};
		settle();

		// Zero window length behaves as one sample: every sample closes a
		// window, and the eleventh closes the default slow interval.
		write_reg(cpa_pkg::REG_SPW, 16'h0000);
		settings++;
		sample_q = '{10'd1023, 10'd1023, 10'd1023, 10'd0, 10'd0, 10'd0, 10'd512, 10'd512,
			10'd1023, 10'd0, 10'd512};
		settle();

		// Full alpha, zero calibration (upper data bits set), zero slow
		// length, top limit, and writes to indexes that hold no register.
		write_reg(cpa_pkg::REG_ALPHA, 16'hFFFF);
		write_reg(cpa_pkg::REG_CALIB, 16'hFC00);
		write_reg(cpa_pkg::REG_WPS, 16'hFF00);
		write_reg(cpa_pkg::REG_AMP_LIMIT, 16'hFFFF);
		write_reg(REG_UNUSED, 16'hFFFF);
		write_reg(REG_SPARE, 16'h5A5A);
		settings++;
		sample_q = '{10'd515, 10'd0, 10'd1023, 10'd512, 10'd513, 10'd2, 10'd0, 10'd0, 10'd1};
		settle();

		// Random phases, each with fresh register values; the first few pin
		// one or two registers at an extreme.
		for (ph = 0; ph < RAND_PHASES; ph++) begin
			alpha_v = (ph == 0) ? 16'hFFFF : (ph == 1) ? 16'h0000
				: cpa_pkg::ALPHA_W'($urandom_range(256, 65535));
			cal_v = (ph == 2) ? 10'd1 : (ph == 3) ? 10'd1023
				: cpa_pkg::CAL_W'($urandom_range(1, 400));
			spw_v = (ph == 4) ? 16'd1 : cpa_pkg::SPW_W'($urandom_range(1, 24));
			wps_v = (ph == 4) ? 8'd255 : cpa_pkg::WPS_W'($urandom_range(0, 6));
			lim_v = (ph == 5) ? 10'd0 : (ph == 6) ? 10'd1023
				: cpa_pkg::LIMIT_W'($urandom_range(0, 80));
			n     = (ph == 4) ? 200 : 100;
			write_reg(cpa_pkg::REG_ALPHA, alpha_v);
			write_reg(cpa_pkg::REG_CALIB, {6'($urandom), cal_v});
			write_reg(cpa_pkg::REG_SPW, spw_v);
			write_reg(cpa_pkg::REG_WPS, {8'($urandom), wps_v});
			write_reg(cpa_pkg::REG_AMP_LIMIT, {6'($urandom), lim_v});
			settings++;
			queue_samples(n);
			settle();
		end

		// Full speed on both sides: short windows and slow intervals with no
		// idle cycle on either channel.
		write_reg(cpa_pkg::REG_SPW, cpa_pkg::CFG_DATA_W'($urandom_range(1, 12)));
		write_reg(cpa_pkg::REG_WPS, cpa_pkg::CFG_DATA_W'($urandom_range(1, 4)));
		write_reg(cpa_pkg::REG_ALPHA, cpa_pkg::CFG_DATA_W'($urandom_range(1024, 65535)));
		settings++;
		no_gaps = 1'b1;
		queue_samples(120);
		settle();
		no_gaps = 1'b0;

		$display("Run: %0d samples, %0d window results checked, %0d closing a slow average",
			samples_taken, windows_checked, slow_updates);
		$display("Run: %0d register settings incl. zero, minimum and full-scale values",
			settings);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches", errors);
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

FILE: filelist.f
design/cpa_pkg.sv
design/cpa_if.sv
design/cpa_mul.sv
design/cpa_div.sv
design/ac_current_peak_ammeter_core.sv
design/cpa_checker.sv
tb/ac_current_peak_ammeter_core_tb.sv
